/* design/kcs_pkg.sv */
`default_nettype none

package kcs_pkg;

  localparam int ALPHA_SIZE = 33;
  localparam int ALPHA_AW   = $clog2(ALPHA_SIZE);
  localparam int ALPHA_CW   = $clog2(ALPHA_SIZE + 1);

  localparam logic [ALPHA_CW-1:0] ALPHA_N    = ALPHA_CW'(ALPHA_SIZE);
  localparam logic [ALPHA_AW-1:0] ALPHA_LAST = ALPHA_AW'(ALPHA_SIZE - 1);

  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_APPEND  = 2'd1;
  localparam logic [1:0] KIND_ENCRYPT = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_REPEAT  = 2'd1;
  localparam logic [1:0] STAT_TOOLONG = 2'd2;
  localparam logic [1:0] STAT_INVALID = 2'd3;

  localparam logic [7:0] LETTER_YO    = 8'hB8;
  localparam logic [7:0] LETTER_FIRST = 8'hE0;
  localparam logic [7:0] LETTER_ZHE   = 8'hE6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_BUILD,
    ST_ADDR,
    ST_LOOK
  } top_state_t;

  typedef enum logic [2:0] {
    BLD_IDLE,
    BLD_RD,
    BLD_WR,
    BLD_FILL,
    BLD_DONE
  } bld_state_t;

  typedef struct packed {
    logic                start;
    logic [ALPHA_CW-1:0] count;
    logic [ALPHA_AW-1:0] shift_mod;
  } bld_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bld_sts_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c == LETTER_YO) || (c >= LETTER_FIRST);
  endfunction

  // position in alphabet order, yo sits after the sixth letter
  function automatic logic [ALPHA_AW-1:0] pos_of(input logic [7:0] c);
    logic [7:0] p;
    if (c == LETTER_YO) begin
      p = 8'd6;
    end else if (c < LETTER_ZHE) begin
      p = c - LETTER_FIRST;
    end else begin
      p = c - LETTER_ZHE + 8'd7;
    end
    return p[ALPHA_AW-1:0];
  endfunction

  // rank by byte value, yo first
  function automatic logic [ALPHA_AW-1:0] rank_of(input logic [7:0] c);
    logic [7:0] r;
    if (c == LETTER_YO) begin
      r = 8'd0;
    end else begin
      r = c - LETTER_FIRST + 8'd1;
    end
    return r[ALPHA_AW-1:0];
  endfunction

  function automatic logic [7:0] letter_by_rank(input logic [ALPHA_CW-1:0] r);
    logic [7:0] c;
    if (r == '0) begin
      c = LETTER_YO;
    end else begin
      c = LETTER_FIRST + 8'(r) - 8'd1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/keyword_shift_substitution_cipher_core.sv */
`default_nettype none

// Keyword Caesar substitution over the 33 lower-case Cyrillic letters of code page
// 1251 (0xB8 and 0xE0-0xFF). in_tuser selects the operation: clear keyword, append
// keyword byte, or encrypt text byte; the result word echoes the input byte (or its
// cipher letter) with a status code. Clear, unused kinds, appends that are refused or
// go to an empty keyword, and encrypts that need no table read (non-letter, invalid
// or empty keyword) are answered straight from the idle state. Any other append
// compares the byte against every byte held, a read then a compare on the keyword
// store for each, and ends early on a repeat. An encrypt of a letter with the table
// in place goes through the registered read of the table memory. The first letter
// encrypt after a keyword change or a shift write rebuilds the table first: a read
// of the keyword store then a write of the table for each keyword byte, then a
// scan of the alphabet for the free letters, then it closes the build and addresses
// the table. The block takes no word while working, and a new word only when the
// output register is empty or being emptied in the same cycle.

module keyword_shift_substitution_cipher_core
  import kcs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [5:0] cfg_wdata,  // shift
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // data
  input  wire logic [1:0] in_tuser,   // kind
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata,  // out_byte
  output logic      [1:0] out_tuser   // status
);

  top_state_t          state_r, state_nxt;
  logic [5:0]          shift_r, shift_nxt;
  logic [ALPHA_CW-1:0] count_r, count_nxt;
  logic [ALPHA_CW-1:0] scan_r, scan_nxt;
  logic                built_r, built_nxt;
  logic                invalid_r, invalid_nxt;
  logic [7:0]          data_r, data_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_data_r, out_data_nxt;
  logic [1:0]          out_stat_r, out_stat_nxt;

  logic                accept;
  logic                st_we;
  logic [7:0]          st_wdata;
  logic [7:0]          st_rdata;
  logic [ALPHA_AW-1:0] st_raddr;
  logic [ALPHA_AW-1:0] bld_raddr;
  logic                tbl_we;
  logic [ALPHA_AW-1:0] tbl_waddr;
  logic [7:0]          tbl_wdata;
  logic [ALPHA_AW-1:0] tbl_raddr;
  logic [7:0]          tbl_rdata;
  logic                bld_start;
  bld_ctl_t            bld_ctl;
  bld_sts_t            bld_sts;

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;
  assign tbl_raddr  = (state_r == ST_IDLE) ? pos_of(in_tdata) : pos_of(data_r);
  assign st_raddr   = (state_r == ST_BUILD) ? bld_raddr : scan_r[ALPHA_AW-1:0];
  assign st_wdata   = (state_r == ST_IDLE) ? in_tdata : data_r;

  assign bld_ctl.start     = bld_start;
  assign bld_ctl.count     = count_r;
  assign bld_ctl.shift_mod = (shift_r >= 6'(ALPHA_SIZE)) ? shift_r - 6'(ALPHA_SIZE)
                                                          : shift_r;

  kcs_ram #(.WIDTH(8), .DEPTH(ALPHA_SIZE)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (count_r[ALPHA_AW-1:0]),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  kcs_ram #(.WIDTH(8), .DEPTH(ALPHA_SIZE)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  kcs_table_build u_build (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (bld_ctl),
    .store_rdata (st_rdata),
    .store_raddr (bld_raddr),
    .tbl_we      (tbl_we),
    .tbl_waddr   (tbl_waddr),
    .tbl_wdata   (tbl_wdata),
    .sts         (bld_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      shift_r     <= '0;
      count_r     <= '0;
      built_r     <= 1'b0;
      invalid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      shift_r     <= shift_nxt;
      count_r     <= count_nxt;
      built_r     <= built_nxt;
      invalid_r   <= invalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    scan_r     <= scan_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    shift_nxt     = shift_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    built_nxt     = built_r;
    invalid_nxt   = invalid_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    st_we         = 1'b0;
    bld_start     = 1'b0;

    if (cfg_we) begin
      shift_nxt = cfg_wdata;
      built_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          data_nxt      = in_tdata;
          out_valid_nxt = 1'b1;
          out_data_nxt  = in_tdata;
          out_stat_nxt  = STAT_OK;
          case (in_tuser)
            KIND_CLEAR: begin
              count_nxt   = '0;
              invalid_nxt = 1'b0;
              built_nxt   = 1'b0;
            end
            KIND_APPEND: begin
              if (invalid_r) begin
                out_stat_nxt = STAT_INVALID;
              end else if (count_r == ALPHA_N) begin
                invalid_nxt  = 1'b1;
                out_stat_nxt = STAT_TOOLONG;
              end else if (count_r == '0) begin
                st_we     = 1'b1;
                count_nxt = count_r + 1'b1;
                built_nxt = 1'b0;
              end else begin
                out_valid_nxt = 1'b0;
                scan_nxt      = '0;
                state_nxt     = ST_SCAN_RD;
              end
            end
            KIND_ENCRYPT: begin
              if (invalid_r) begin
                out_stat_nxt = STAT_INVALID;
              end else if (count_r != '0 && is_letter(in_tdata)) begin
                out_valid_nxt = 1'b0;
                if (built_r) begin
                  state_nxt = ST_LOOK;
                end else begin
                  bld_start = 1'b1;
                  state_nxt = ST_BUILD;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      // repeat check against the stored keyword bytes
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (st_rdata == data_r) begin
          invalid_nxt   = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r;
          out_stat_nxt  = STAT_REPEAT;
          state_nxt     = ST_IDLE;
        end else if (scan_r + 1'b1 == count_r) begin
          st_we         = 1'b1;
          count_nxt     = count_r + 1'b1;
          built_nxt     = 1'b0;
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r;
          out_stat_nxt  = STAT_OK;
          state_nxt     = ST_IDLE;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_BUILD: begin
        if (bld_sts.done) begin
          built_nxt = 1'b1;
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: begin
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = tbl_rdata;
        out_stat_nxt  = STAT_OK;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ALPHA_N)
    else $error("keyword count past alphabet size");

  a_build_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUILD && bld_sts.done) |=> built_r)
    else $error("table not marked built after build");

  a_no_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_valid_r)
    else $error("result pending while table work in progress");

  a_invalid_stat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r == STAT_INVALID) |-> invalid_r)
    else $error("invalid status without invalid keyword");

  a_build_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !bld_sts.busy)
    else $error("builder busy while core idle");
`endif

endmodule

`default_nettype wire

/* design/kcs_ram.sv */
`default_nettype none

module kcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 33
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* design/kcs_table_build.sv */
`default_nettype none

module kcs_table_build
  import kcs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bld_ctl_t            ctl,
  input  wire logic [7:0]          store_rdata,
  output logic      [ALPHA_AW-1:0] store_raddr,
  output logic                     tbl_we,
  output logic      [ALPHA_AW-1:0] tbl_waddr,
  output logic      [7:0]          tbl_wdata,
  output bld_sts_t                 sts
);

  bld_state_t            state_r, state_nxt;
  logic [ALPHA_CW-1:0]   k_r, k_nxt;
  logic [ALPHA_AW-1:0]   pos_r, pos_nxt;
  logic [ALPHA_CW-1:0]   rank_r, rank_nxt;
  logic [ALPHA_SIZE-1:0] used_r, used_nxt;
  logic [ALPHA_AW-1:0]   pos_inc;

  assign pos_inc     = (pos_r == ALPHA_LAST) ? '0 : pos_r + 1'b1;
  assign store_raddr = k_r[ALPHA_AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BLD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    pos_r  <= pos_nxt;
    rank_r <= rank_nxt;
    used_r <= used_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;
    rank_nxt  = rank_r;
    used_nxt  = used_r;
    tbl_we    = 1'b0;
    tbl_waddr = pos_r;
    tbl_wdata = store_rdata;
    sts.busy  = (state_r != BLD_IDLE);
    sts.done  = 1'b0;
    case (state_r)
      BLD_IDLE: begin
        if (ctl.start) begin
          k_nxt     = '0;
          pos_nxt   = ctl.shift_mod;
          rank_nxt  = '0;
          used_nxt  = '0;
          state_nxt = BLD_RD;
        end
      end
      BLD_RD: begin
        state_nxt = BLD_WR;
      end
      // keyword pass: each stored byte is read, then written to the table
      BLD_WR: begin
        tbl_we  = 1'b1;
        k_nxt   = k_r + 1'b1;
        pos_nxt = pos_inc;
        if (is_letter(store_rdata)) begin
          used_nxt[rank_of(store_rdata)] = 1'b1;
        end
        state_nxt = (k_nxt == ctl.count) ? BLD_FILL : BLD_RD;
      end
      // scan the alphabet by byte value for the free letters
      BLD_FILL: begin
        if (k_r == ALPHA_N) begin
          state_nxt = BLD_DONE;
        end else begin
          rank_nxt = rank_r + 1'b1;
          if (!used_r[rank_r[ALPHA_AW-1:0]]) begin
            tbl_we    = 1'b1;
            tbl_wdata = letter_by_rank(rank_r);
            k_nxt     = k_r + 1'b1;
            pos_nxt   = pos_inc;
          end
        end
      end
      BLD_DONE: begin
        sts.done  = 1'b1;
        state_nxt = BLD_IDLE;
      end
      default: begin
        state_nxt = BLD_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
